// ----- hw/rtl/qs2m_pkg.sv -----
package qs2m_pkg;

    localparam int IN_W    = 16;
    localparam int TR_W    = 32;
    localparam int OUT_W   = 32;
    localparam int MUL1_W  = 2 * IN_W;
    localparam int TERM_W  = MUL1_W + 3;
    localparam int MUL2_W  = TERM_W + IN_W;
    localparam int RND_W   = MUL2_W + 2;
    localparam int FRAC_SHIFT = 20;
    localparam int Q_W     = RND_W - FRAC_SHIFT;

    localparam logic [1:0] ROW_LAST = 2'd3;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_SUB  = 2'd1;
    localparam logic [1:0] MODE_DIAG = 2'd2;

    localparam logic signed [TERM_W-1:0] ONE_Q28  = TERM_W'(64'sd1 <<< 28);
    localparam logic signed [RND_W-1:0]  RND_HALF = RND_W'(64'sd1 <<< (FRAC_SHIFT - 1));
    localparam logic signed [OUT_W-1:0]  ONE_Q16  = OUT_W'(64'sd1 <<< 16);

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-64'sh0000_0000_8000_0000);

endpackage

// ----- hw/rtl/quat_scale_to_matrix_core.sv -----
// Channel | Direction | Payload
// s_      | input     | quat_x/y/z/w (Q2.14), scale_x/y/z (Q8.8), trans_x/y/z (Q16.16)
// m_      | output    | row_index, col0..col3 (Q16.16), last on row 3
//
// Each input transfer yields four output transfers, one row per cycle while m_ready does
// not stall; the row sequencer takes a new transform only when idle or issuing row 3.
// Row 0 passes from the input hold registers into the row pipeline, which has four stages
// (product, sum, scale multiply, round and saturate into the output register).
// Reset is synchronous, active low, and clears the sequencer and all valid bits.
// A stall on m_ready freezes the whole pipeline; no row is lost or repeated.
module quat_scale_to_matrix_core
    import qs2m_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [IN_W-1:0]   s_quat_x,
    input  logic signed [IN_W-1:0]   s_quat_y,
    input  logic signed [IN_W-1:0]   s_quat_z,
    input  logic signed [IN_W-1:0]   s_quat_w,
    input  logic signed [IN_W-1:0]   s_scale_x,
    input  logic signed [IN_W-1:0]   s_scale_y,
    input  logic signed [IN_W-1:0]   s_scale_z,
    input  logic signed [TR_W-1:0]   s_trans_x,
    input  logic signed [TR_W-1:0]   s_trans_y,
    input  logic signed [TR_W-1:0]   s_trans_z,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_row_index,
    output logic signed [OUT_W-1:0]  m_col0,
    output logic signed [OUT_W-1:0]  m_col1,
    output logic signed [OUT_W-1:0]  m_col2,
    output logic signed [OUT_W-1:0]  m_col3,
    output logic                     m_last
);

    logic en;

    logic                     busy_reg;
    logic [1:0]               row_cnt_reg;
    logic signed [IN_W-1:0]   quat_hold_reg  [4];
    logic signed [IN_W-1:0]   scale_hold_reg [3];
    logic signed [TR_W-1:0]   trans_hold_reg [3];

    logic signed [IN_W-1:0]   opa_next [3][2];
    logic signed [IN_W-1:0]   opb_next [3][2];
    logic [1:0]               mode_next [3];
    logic signed [IN_W-1:0]   scale_next;

    logic                     s1_valid_reg;
    logic [1:0]               s1_row_reg;
    logic [1:0]               s1_mode_reg  [3];
    logic signed [MUL1_W-1:0] s1_prod_reg  [3][2];
    logic signed [IN_W-1:0]   s1_scale_reg;
    logic signed [TR_W-1:0]   s1_trans_reg [3];

    logic signed [TERM_W-1:0] term_next [3];

    logic                     s2_valid_reg;
    logic [1:0]               s2_row_reg;
    logic signed [TERM_W-1:0] s2_term_reg  [3];
    logic signed [IN_W-1:0]   s2_scale_reg;
    logic signed [TR_W-1:0]   s2_trans_reg [3];

    logic signed [MUL2_W-1:0] mul_next [3];

    logic                     s3_valid_reg;
    logic [1:0]               s3_row_reg;
    logic signed [MUL2_W-1:0] s3_mul_reg   [3];
    logic signed [TR_W-1:0]   s3_trans_reg [3];

    logic signed [OUT_W-1:0]  col_next [3];

    logic                     m_valid_reg;
    logic [1:0]               m_row_reg;
    logic signed [OUT_W-1:0]  m_col_reg [4];
    logic                     m_last_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = !busy_reg || (en && row_cnt_reg == ROW_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            row_cnt_reg <= 2'd0;
        end else begin
            if (en && busy_reg) begin
                row_cnt_reg <= row_cnt_reg + 2'd1;
                if (row_cnt_reg == ROW_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
            if (s_valid && s_ready) begin
                busy_reg    <= 1'b1;
                row_cnt_reg <= 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            quat_hold_reg[0]  <= s_quat_x;
            quat_hold_reg[1]  <= s_quat_y;
            quat_hold_reg[2]  <= s_quat_z;
            quat_hold_reg[3]  <= s_quat_w;
            scale_hold_reg[0] <= s_scale_x;
            scale_hold_reg[1] <= s_scale_y;
            scale_hold_reg[2] <= s_scale_z;
            trans_hold_reg[0] <= s_trans_x;
            trans_hold_reg[1] <= s_trans_y;
            trans_hold_reg[2] <= s_trans_z;
        end
    end

    // Operand pairs for the three entries of the row being issued.
    always_comb begin
        logic signed [IN_W-1:0] qx, qy, qz, qw;
        qx = quat_hold_reg[0];
        qy = quat_hold_reg[1];
        qz = quat_hold_reg[2];
        qw = quat_hold_reg[3];
        for (int e = 0; e < 3; e++) begin
            for (int k = 0; k < 2; k++) begin
                opa_next[e][k] = '0;
                opb_next[e][k] = '0;
            end
            mode_next[e] = MODE_ADD;
        end
        scale_next = '0;
        unique case (row_cnt_reg)
            2'd0: begin
                opa_next[0][0] = qy; opb_next[0][0] = qy;
                opa_next[0][1] = qz; opb_next[0][1] = qz;
                opa_next[1][0] = qx; opb_next[1][0] = qy;
                opa_next[1][1] = qw; opb_next[1][1] = qz;
                opa_next[2][0] = qx; opb_next[2][0] = qz;
                opa_next[2][1] = qw; opb_next[2][1] = qy;
                mode_next[0] = MODE_DIAG;
                mode_next[1] = MODE_ADD;
                mode_next[2] = MODE_SUB;
                scale_next   = scale_hold_reg[0];
            end
            2'd1: begin
                opa_next[0][0] = qx; opb_next[0][0] = qy;
                opa_next[0][1] = qw; opb_next[0][1] = qz;
                opa_next[1][0] = qx; opb_next[1][0] = qx;
                opa_next[1][1] = qz; opb_next[1][1] = qz;
                opa_next[2][0] = qy; opb_next[2][0] = qz;
                opa_next[2][1] = qw; opb_next[2][1] = qx;
                mode_next[0] = MODE_SUB;
                mode_next[1] = MODE_DIAG;
                mode_next[2] = MODE_ADD;
                scale_next   = scale_hold_reg[1];
            end
            2'd2: begin
                opa_next[0][0] = qx; opb_next[0][0] = qz;
                opa_next[0][1] = qw; opb_next[0][1] = qy;
                opa_next[1][0] = qy; opb_next[1][0] = qz;
                opa_next[1][1] = qw; opb_next[1][1] = qx;
                opa_next[2][0] = qx; opb_next[2][0] = qx;
                opa_next[2][1] = qy; opb_next[2][1] = qy;
                mode_next[0] = MODE_ADD;
                mode_next[1] = MODE_SUB;
                mode_next[2] = MODE_DIAG;
                scale_next   = scale_hold_reg[2];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= busy_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_row_reg   <= row_cnt_reg;
            s1_scale_reg <= scale_next;
            for (int e = 0; e < 3; e++) begin
                s1_mode_reg[e]  <= mode_next[e];
                s1_trans_reg[e] <= trans_hold_reg[e];
                for (int k = 0; k < 2; k++) begin
                    s1_prod_reg[e][k] <= opa_next[e][k] * opb_next[e][k];
                end
            end
        end
    end

    always_comb begin
        logic signed [TERM_W-1:0] p0, p1, dbl_sum, dbl_diff;
        for (int e = 0; e < 3; e++) begin
            p0 = {{(TERM_W-MUL1_W){s1_prod_reg[e][0][MUL1_W-1]}}, s1_prod_reg[e][0]};
            p1 = {{(TERM_W-MUL1_W){s1_prod_reg[e][1][MUL1_W-1]}}, s1_prod_reg[e][1]};
            dbl_sum  = (p0 + p1) <<< 1;
            dbl_diff = (p0 - p1) <<< 1;
            case (s1_mode_reg[e])
                MODE_ADD:  term_next[e] = dbl_sum;
                MODE_SUB:  term_next[e] = dbl_diff;
                MODE_DIAG: term_next[e] = ONE_Q28 - dbl_sum;
                default:   term_next[e] = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_row_reg   <= s1_row_reg;
            s2_scale_reg <= s1_scale_reg;
            for (int e = 0; e < 3; e++) begin
                s2_term_reg[e]  <= term_next[e];
                s2_trans_reg[e] <= s1_trans_reg[e];
            end
        end
    end

    always_comb begin
        logic signed [MUL2_W-1:0] t_ext, s_ext;
        for (int e = 0; e < 3; e++) begin
            t_ext = {{(MUL2_W-TERM_W){s2_term_reg[e][TERM_W-1]}}, s2_term_reg[e]};
            s_ext = {{(MUL2_W-IN_W){s2_scale_reg[IN_W-1]}}, s2_scale_reg};
            mul_next[e] = t_ext * s_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_row_reg <= s2_row_reg;
            for (int e = 0; e < 3; e++) begin
                s3_mul_reg[e]   <= mul_next[e];
                s3_trans_reg[e] <= s2_trans_reg[e];
            end
        end
    end

    // Round half up into Q16.16, then clamp to the 32-bit range.
    always_comb begin
        logic signed [RND_W-1:0] rnd;
        logic signed [Q_W-1:0]   q;
        for (int e = 0; e < 3; e++) begin
            rnd = {{(RND_W-MUL2_W){s3_mul_reg[e][MUL2_W-1]}}, s3_mul_reg[e]} + RND_HALF;
            q   = rnd[RND_W-1:FRAC_SHIFT];
            if (q > Q_MAX) begin
                col_next[e] = OUT_W'(Q_MAX);
            end else if (q < Q_MIN) begin
                col_next[e] = OUT_W'(Q_MIN);
            end else begin
                col_next[e] = q[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_row_reg <= s3_row_reg;
            if (s3_row_reg == ROW_LAST) begin
                for (int e = 0; e < 3; e++) begin
                    m_col_reg[e] <= s3_trans_reg[e];
                end
                m_col_reg[3] <= ONE_Q16;
                m_last_reg   <= 1'b1;
            end else begin
                for (int e = 0; e < 3; e++) begin
                    m_col_reg[e] <= col_next[e];
                end
                m_col_reg[3] <= '0;
                m_last_reg   <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_row_index = m_row_reg;
    assign m_col0      = m_col_reg[0];
    assign m_col1      = m_col_reg[1];
    assign m_col2      = m_col_reg[2];
    assign m_col3      = m_col_reg[3];
    assign m_last      = m_last_reg;

`ifndef SYNTHESIS
    a_no_accept_mid_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && row_cnt_reg != ROW_LAST) |-> !s_ready)
        else $error("input accepted while rows of the previous item are pending");

    a_valid_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && s1_valid_reg) |=> s2_valid_reg)
        else $error("pipeline valid bit lost between stages");

    a_last_on_row3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_row_index == ROW_LAST)))
        else $error("last flag does not match row index");

    a_col3_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_row_index != ROW_LAST) |-> (m_col3 == '0))
        else $error("column 3 nonzero on a rotation row");
`endif

endmodule

// ----- tb/tb_quat_scale_to_matrix_core.sv -----
module tb_quat_scale_to_matrix_core
    import qs2m_pkg::*;
();

    localparam int     CYCLE_LIMIT  = 100000;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     TAIL_CYCLES  = 20;
    localparam longint UNIT_Q28     = 64'sd1 <<< 28;
    localparam longint ROUND_HALF   = 64'sd1 <<< 19;
    localparam longint SAT_MAX      = 64'sd2147483647;
    localparam longint SAT_MIN      = -64'sd2147483648;

    typedef struct {
        logic signed [IN_W-1:0] quat_x;
        logic signed [IN_W-1:0] quat_y;
        logic signed [IN_W-1:0] quat_z;
        logic signed [IN_W-1:0] quat_w;
        logic signed [IN_W-1:0] scale_x;
        logic signed [IN_W-1:0] scale_y;
        logic signed [IN_W-1:0] scale_z;
        logic signed [TR_W-1:0] trans_x;
        logic signed [TR_W-1:0] trans_y;
        logic signed [TR_W-1:0] trans_z;
    } xform_t;

    typedef struct {
        logic [1:0]              row_index;
        logic signed [OUT_W-1:0] col0;
        logic signed [OUT_W-1:0] col1;
        logic signed [OUT_W-1:0] col2;
        logic signed [OUT_W-1:0] col3;
        logic                    last;
    } matrix_row_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic signed [IN_W-1:0]  s_quat_x  = '0;
    logic signed [IN_W-1:0]  s_quat_y  = '0;
    logic signed [IN_W-1:0]  s_quat_z  = '0;
    logic signed [IN_W-1:0]  s_quat_w  = '0;
    logic signed [IN_W-1:0]  s_scale_x = '0;
    logic signed [IN_W-1:0]  s_scale_y = '0;
    logic signed [IN_W-1:0]  s_scale_z = '0;
    logic signed [TR_W-1:0]  s_trans_x = '0;
    logic signed [TR_W-1:0]  s_trans_y = '0;
    logic signed [TR_W-1:0]  s_trans_z = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic [1:0]              m_row_index;
    logic signed [OUT_W-1:0] m_col0;
    logic signed [OUT_W-1:0] m_col1;
    logic signed [OUT_W-1:0] m_col2;
    logic signed [OUT_W-1:0] m_col3;
    logic                    m_last;

    matrix_row_t rows_due[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    bit          hold_req    = 1'b0;
    int          hold_cnt    = 0;

    quat_scale_to_matrix_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_quat_x    (s_quat_x),
        .s_quat_y    (s_quat_y),
        .s_quat_z    (s_quat_z),
        .s_quat_w    (s_quat_w),
        .s_scale_x   (s_scale_x),
        .s_scale_y   (s_scale_y),
        .s_scale_z   (s_scale_z),
        .s_trans_x   (s_trans_x),
        .s_trans_y   (s_trans_y),
        .s_trans_z   (s_trans_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_col0      (m_col0),
        .m_col1      (m_col1),
        .m_col2      (m_col2),
        .m_col3      (m_col3),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [OUT_W-1:0] round_sat_q16(longint prod);
        longint v;
        v = (prod + ROUND_HALF) >>> 20;
        if (v > SAT_MAX) v = SAT_MAX;
        if (v < SAT_MIN) v = SAT_MIN;
        return OUT_W'(v);
    endfunction

    function automatic void predict_matrix(xform_t t);
        longint x, y, z, w, sx, sy, sz;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        matrix_row_t r;
        x  = t.quat_x;
        y  = t.quat_y;
        z  = t.quat_z;
        w  = t.quat_w;
        sx = t.scale_x;
        sy = t.scale_y;
        sz = t.scale_z;
        xx = 2 * x * x;
        yy = 2 * y * y;
        zz = 2 * z * z;
        xy = 2 * x * y;
        xz = 2 * x * z;
        yz = 2 * y * z;
        wx = 2 * w * x;
        wy = 2 * w * y;
        wz = 2 * w * z;

        r.row_index = 2'd0;
        r.col0 = round_sat_q16((UNIT_Q28 - (yy + zz)) * sx);
        r.col1 = round_sat_q16((xy + wz) * sx);
        r.col2 = round_sat_q16((xz - wy) * sx);
        r.col3 = '0;
        r.last = 1'b0;
        rows_due.push_back(r);

        r.row_index = 2'd1;
        r.col0 = round_sat_q16((xy - wz) * sy);
        r.col1 = round_sat_q16((UNIT_Q28 - (xx + zz)) * sy);
        r.col2 = round_sat_q16((yz + wx) * sy);
        rows_due.push_back(r);

        r.row_index = 2'd2;
        r.col0 = round_sat_q16((xz + wy) * sz);
        r.col1 = round_sat_q16((yz - wx) * sz);
        r.col2 = round_sat_q16((UNIT_Q28 - (xx + yy)) * sz);
        rows_due.push_back(r);

        r.row_index = ROW_LAST;
        r.col0 = t.trans_x;
        r.col1 = t.trans_y;
        r.col2 = t.trans_z;
        r.col3 = ONE_Q16;
        r.last = 1'b1;
        rows_due.push_back(r);
    endfunction

    task automatic check_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Results are checked before the input transfer of the same edge is predicted.
    always @(posedge aclk) begin
        matrix_row_t exp_row;
        xform_t      seen;
        if (aresetn && m_valid && m_ready) begin
            if (rows_due.size() == 0) begin
                $error("unexpected result transfer: row_index %0d", m_row_index);
                fail_count++;
            end else begin
                exp_row = rows_due.pop_front();
                check_field("row_index", OUT_W'(exp_row.row_index), OUT_W'(m_row_index));
                check_field("col0", exp_row.col0, m_col0);
                check_field("col1", exp_row.col1, m_col1);
                check_field("col2", exp_row.col2, m_col2);
                check_field("col3", exp_row.col3, m_col3);
                check_field("last", OUT_W'(exp_row.last), OUT_W'(m_last));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            seen.quat_x  = s_quat_x;
            seen.quat_y  = s_quat_y;
            seen.quat_z  = s_quat_z;
            seen.quat_w  = s_quat_w;
            seen.scale_x = s_scale_x;
            seen.scale_y = s_scale_y;
            seen.scale_z = s_scale_z;
            seen.trans_x = s_trans_x;
            seen.trans_y = s_trans_y;
            seen.trans_z = s_trans_z;
            predict_matrix(seen);
        end
    end

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 99) < 10) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic xform_t make_xform(int qx, int qy, int qz, int qw,
                                          int sx, int sy, int sz,
                                          int tx, int ty, int tz);
        xform_t t;
        t.quat_x  = IN_W'(qx);
        t.quat_y  = IN_W'(qy);
        t.quat_z  = IN_W'(qz);
        t.quat_w  = IN_W'(qw);
        t.scale_x = IN_W'(sx);
        t.scale_y = IN_W'(sy);
        t.scale_z = IN_W'(sz);
        t.trans_x = TR_W'(tx);
        t.trans_y = TR_W'(ty);
        t.trans_z = TR_W'(tz);
        return t;
    endfunction

    function automatic xform_t rand_xform();
        xform_t t;
        if ($urandom_range(0, 1) == 0) begin
            t = make_xform($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom);
        end else begin
            t = make_xform(int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 32768)) - 16384,
                           int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024,
                           int'($urandom_range(0, 2048)) - 1024,
                           $urandom, $urandom, $urandom);
        end
        return t;
    endfunction

    // Called right after a rising edge; returns after the transfer or an idle gap.
    task automatic send_xform(xform_t t);
        int gap;
        s_valid   <= 1'b1;
        s_quat_x  <= t.quat_x;
        s_quat_y  <= t.quat_y;
        s_quat_z  <= t.quat_z;
        s_quat_w  <= t.quat_w;
        s_scale_x <= t.scale_x;
        s_scale_y <= t.scale_y;
        s_scale_z <= t.scale_z;
        s_trans_x <= t.trans_x;
        s_trans_y <= t.trans_y;
        s_trans_z <= t.trans_z;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (tx_idle_en && $urandom_range(0, 99) < 10) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_rows_drained();
        s_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        send_xform(make_xform(0, 0, 0, 16384, 256, 256, 256, 0, 0, 0));
        send_xform(make_xform(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_xform(make_xform(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                              32'h80000000, 32'h80000000, 32'h80000000));
        send_xform(make_xform(0, 0, 0, 0, 32767, 32767, 32767, 0, 0, 0));
        send_xform(make_xform(0, 0, 0, 0, -32768, -32768, -32768, 1, -1, 0));
        send_xform(make_xform(-32768, 0, 0, 0, -32768, 32767, -32768, 0, 0, 0));
        send_xform(make_xform(-32768, -32768, -32768, 32767, 32767, -32768, 32767,
                              32'h7FFFFFFF, 32'h80000000, 1));
        send_xform(make_xform(0, 0, 11585, 11585, 256, 256, 256, 32'h00010000, 0, 0));
        send_xform(make_xform(11585, 0, 0, 11585, -256, 512, -512, 0, 32'hFFFF0000, 0));
        send_xform(make_xform(0, 16384, 0, 0, 256, 256, 256, 0, 0, 32'h00008000));
        send_xform(make_xform(0, 0, 0, 16384, -256, -256, -256, 0, 0, 0));
        send_xform(make_xform(16384, 16384, 16384, 16384, 0, 0, 0, 0, 0, 0));
        send_xform(make_xform(1, 1, 1, 1, 1, 1, 1, 0, 0, 0));
        send_xform(make_xform(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_xform(make_xform(8192, -8192, 8192, -8192, 128, -128, 1, 2, 3, 4));
        send_xform(make_xform(32767, 0, -32768, 0, 1, -1, 32767,
                              32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F));
        send_xform(make_xform(0, 32767, 0, -32768, -32768, 1, -1,
                              32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0));
        wait_rows_drained();
    endtask

    task automatic test_output_stall();
        @(posedge aclk);
        hold_req = 1'b1;
        repeat (12) send_xform(rand_xform());
        wait_rows_drained();
    endtask

    task automatic test_random_xforms(int count, bit with_idle);
        tx_idle_en = with_idle;
        rx_idle_en = with_idle;
        repeat (count) send_xform(rand_xform());
        wait_rows_drained();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_output_stall();
        test_random_xforms(25, 1'b0);
        test_random_xforms(45, 1'b1);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
